/* rtl/sliding_window_sorted_buffer_defines.svh */
// Assertion macros shared by the checker.
`ifndef SLIDING_WINDOW_SORTED_BUFFER_DEFINES_SVH
`define SLIDING_WINDOW_SORTED_BUFFER_DEFINES_SVH

// Check cons in the cycle after ante.
`define SWSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sliding window buffer: next-cycle check failed");

// Check cons in the same cycle as ante.
`define SWSB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sliding window buffer: same-cycle check failed");

`endif

/* rtl/swsb_pkg.sv */
`default_nettype none

package swsb_pkg;

    localparam int WINDOW_MAX  = 16;
    localparam int SAMPLE_BITS = 32;
    localparam int IDX_BITS    = $clog2(WINDOW_MAX);
    localparam int WS_BITS     = 5;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [IDX_BITS-1:0]           idx_t;
    typedef logic [WS_BITS-1:0]            ws_t;

    localparam ws_t WS_MIN   = ws_t'(2);
    localparam ws_t WS_MAX   = ws_t'(WINDOW_MAX);
    localparam ws_t WS_RESET = ws_t'(16);

    typedef struct packed {
        logic    val_we;
        idx_t    val_waddr;
        sample_t val_wdata;
        idx_t    val_raddr;
        logic    own_we;
        idx_t    own_waddr;
        idx_t    own_wdata;
        idx_t    own_raddr;
        logic    pos_we;
        idx_t    pos_waddr;
        idx_t    pos_wdata;
        idx_t    pos_raddr;
    } store_ctrl_t;

    typedef struct packed {
        logic lt;
        logic gt;
    } cmp_res_t;

    function automatic ws_t clamp_size(input ws_t v);
        ws_t r;
        if (v < WS_MIN)
        begin
            r = WS_MIN;
        end
        else if (v > WS_MAX)
        begin
            r = WS_MAX;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/swsb_cmp.sv */
`default_nettype none

module swsb_cmp
    import swsb_pkg::*;
(
    input  sample_t  a,
    input  sample_t  b,
    output cmp_res_t res
);

    assign res.lt = (a < b);
    assign res.gt = (a > b);

endmodule

`default_nettype wire

/* rtl/swsb_store.sv */
`default_nettype none

module swsb_store
    import swsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clear,
    input  store_ctrl_t ctrl,
    output sample_t     val_rdata,
    output idx_t        own_rdata,
    output idx_t        pos_rdata
);

    sample_t val_reg [WINDOW_MAX];
    idx_t    own_reg [WINDOW_MAX];
    idx_t    pos_reg [WINDOW_MAX];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WINDOW_MAX; k++)
            begin
                val_reg[k] <= '0;
                own_reg[k] <= idx_t'(k);
                pos_reg[k] <= idx_t'(k);
            end
        end
        else if (clear)
        begin
            for (int k = 0; k < WINDOW_MAX; k++)
            begin
                val_reg[k] <= '0;
                own_reg[k] <= idx_t'(k);
                pos_reg[k] <= idx_t'(k);
            end
        end
        else
        begin
            if (ctrl.val_we)
            begin
                val_reg[ctrl.val_waddr] <= ctrl.val_wdata;
            end
            if (ctrl.own_we)
            begin
                own_reg[ctrl.own_waddr] <= ctrl.own_wdata;
            end
            if (ctrl.pos_we)
            begin
                pos_reg[ctrl.pos_waddr] <= ctrl.pos_wdata;
            end
        end
    end

    assign val_rdata = val_reg[ctrl.val_raddr];
    assign own_rdata = own_reg[ctrl.own_raddr];
    assign pos_rdata = pos_reg[ctrl.pos_raddr];

endmodule

`default_nettype wire

/* rtl/sliding_window_sorted_buffer.sv */
// channel      | handshake                  | payload
// -------------+----------------------------+------------------------------------------
// sample       | sample_valid / sample_stall | sample
// result       | result_valid / result_stall | insert_position, lowest/middle/highest_value
// window_size  | window_size_we             | window_size
//
// No next beat is taken until the last is through; the new value moves past k entries
// (0 .. window_size-1) in S_SHIFT, where one shared signed comparator probes one neighbor
// per cycle, then S_RD_LO, S_RD_MID and S_RD_HI read the query values. Reset
// (asynchronous, rst_n low) and any window_size write zero the window and restore
// identity maps. A stalled result holds in its output register; the block takes the
// next sample meanwhile and waits before its own result only if still stalled.
`default_nettype none

module sliding_window_sorted_buffer
    import swsb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    window_size_we,
    input  ws_t     window_size,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  sample_t sample,
    output logic    result_valid,
    input  logic    result_stall,
    output idx_t    insert_position,
    output sample_t lowest_value,
    output sample_t middle_value,
    output sample_t highest_value
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_LOOKUP = 8'b0000_0010,
        S_PROBE  = 8'b0000_0100,
        S_SHIFT  = 8'b0000_1000,
        S_PLACE  = 8'b0001_0000,
        S_RD_LO  = 8'b0010_0000,
        S_RD_MID = 8'b0100_0000,
        S_RD_HI  = 8'b1000_0000
    } state_t;

    state_t  state_reg, state_next;
    ws_t     ws_reg;
    idx_t    oldest_reg, oldest_next;
    sample_t x_reg;
    idx_t    slot_reg;
    idx_t    idx_reg, idx_next;
    logic    up_reg, up_next;
    sample_t lo_reg, mid_reg;
    logic    out_valid_reg, out_valid_next;
    idx_t    pos_out_reg;
    sample_t lo_out_reg, mid_out_reg, hi_out_reg;

    store_ctrl_t ctrl;
    sample_t     val_rdata;
    idx_t        own_rdata;
    idx_t        pos_rdata;
    cmp_res_t    cmp;

    idx_t    ws_m1;
    idx_t    ws_half;
    idx_t    idx_adj;
    logic    at_edge;
    logic    move;
    logic    accept;
    logic    load_out;
    ws_t     slot_inc;

    assign ws_m1   = idx_t'(ws_reg - ws_t'(1));
    assign ws_half = idx_t'(ws_reg >> 1);
    assign idx_adj = up_reg ? idx_reg + idx_t'(1) : idx_reg - idx_t'(1);
    assign at_edge = up_reg ? (idx_reg == ws_m1) : (idx_reg == '0);
    assign move    = !at_edge && (up_reg ? !cmp.lt : !cmp.gt);
    assign slot_inc = {1'b0, slot_reg} + ws_t'(1);

    assign sample_stall = (state_reg != S_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign load_out     = (state_reg == S_RD_HI) && (!out_valid_reg || !result_stall);

    swsb_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (window_size_we),
        .ctrl      (ctrl),
        .val_rdata (val_rdata),
        .own_rdata (own_rdata),
        .pos_rdata (pos_rdata)
    );

    swsb_cmp u_cmp (
        .a   (x_reg),
        .b   (val_rdata),
        .res (cmp)
    );

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        up_next     = up_reg;
        oldest_next = oldest_reg;

        ctrl           = '0;
        ctrl.val_raddr = idx_reg;
        ctrl.own_raddr = idx_adj;
        ctrl.pos_raddr = slot_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                idx_next   = ({1'b0, pos_rdata} >= ws_reg) ? ws_m1 : pos_rdata;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                up_next    = cmp.gt;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                ctrl.val_raddr = idx_adj;
                if (move)
                begin
                    ctrl.val_we    = 1'b1;
                    ctrl.val_waddr = idx_reg;
                    ctrl.val_wdata = val_rdata;
                    ctrl.own_we    = 1'b1;
                    ctrl.own_waddr = idx_reg;
                    ctrl.own_wdata = own_rdata;
                    ctrl.pos_we    = 1'b1;
                    ctrl.pos_waddr = own_rdata;
                    ctrl.pos_wdata = idx_reg;
                    idx_next       = idx_adj;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                ctrl.val_we    = 1'b1;
                ctrl.val_waddr = idx_reg;
                ctrl.val_wdata = x_reg;
                ctrl.own_we    = 1'b1;
                ctrl.own_waddr = idx_reg;
                ctrl.own_wdata = slot_reg;
                ctrl.pos_we    = 1'b1;
                ctrl.pos_waddr = slot_reg;
                ctrl.pos_wdata = idx_reg;
                oldest_next    = (slot_inc >= ws_reg) ? '0 : idx_t'(slot_inc);
                state_next     = S_RD_LO;
            end
            S_RD_LO:
            begin
                ctrl.val_raddr = '0;
                state_next     = S_RD_MID;
            end
            S_RD_MID:
            begin
                ctrl.val_raddr = ws_half;
                state_next     = S_RD_HI;
            end
            S_RD_HI:
            begin
                ctrl.val_raddr = ws_m1;
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ws_reg        <= WS_RESET;
            oldest_reg    <= '0;
            up_reg        <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            up_reg        <= up_next;
            out_valid_reg <= out_valid_next;
            if (window_size_we)
            begin
                ws_reg     <= clamp_size(window_size);
                oldest_reg <= '0;
            end
            else
            begin
                oldest_reg <= oldest_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= sample;
            slot_reg <= oldest_reg;
        end
        if (state_reg == S_RD_LO)
        begin
            lo_reg <= val_rdata;
        end
        if (state_reg == S_RD_MID)
        begin
            mid_reg <= val_rdata;
        end
        if (load_out)
        begin
            pos_out_reg <= idx_reg;
            lo_out_reg  <= lo_reg;
            mid_out_reg <= mid_reg;
            hi_out_reg  <= val_rdata;
        end
    end

    assign result_valid    = out_valid_reg;
    assign insert_position = pos_out_reg;
    assign lowest_value    = lo_out_reg;
    assign middle_value    = mid_out_reg;
    assign highest_value   = hi_out_reg;

endmodule

`default_nettype wire

/* rtl/swsb_checker.sv */
`default_nettype none

`include "sliding_window_sorted_buffer_defines.svh"

module swsb_checker
    import swsb_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    sample_valid,
    input wire logic    sample_stall,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire idx_t    insert_position,
    input wire sample_t lowest_value,
    input wire sample_t middle_value,
    input wire sample_t highest_value
);

    logic [IDX_BITS+3*SAMPLE_BITS-1:0] payload_bits;
    assign payload_bits = {insert_position, lowest_value, middle_value, highest_value};

    `SWSB_ASSERT_NEXT(a_result_holds, clk, rst_n, result_valid && result_stall, result_valid)
    `SWSB_ASSERT_NEXT(a_payload_holds, clk, rst_n, result_valid && result_stall, $stable(payload_bits))
    `SWSB_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, sample_valid && !sample_stall, sample_stall)
    `SWSB_ASSERT_SAME(a_window_ordered, clk, rst_n, result_valid, (lowest_value <= middle_value) && (middle_value <= highest_value))

endmodule

bind sliding_window_sorted_buffer swsb_checker u_swsb_checker (.*);

`default_nettype wire
